### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

### design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types, constants and hash helpers for the linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Slot count; must be a power of two (the home hash folds base-TABLE_SIZE digits).
  localparam int TABLE_SIZE  = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int QUEUE_DEPTH = 2;   // power of two
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int NCHUNK = (KEY_W + SLOT_W - 1) / SLOT_W;
  localparam int SUM_W  = SLOT_W + $clog2(NCHUNK) + 1;
  localparam int FOLD_W = SLOT_W + 1;

  localparam logic [FOLD_W-1:0] HOME_MOD   = FOLD_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SIZE - 1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] home;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  // key mod (TABLE_SIZE-1) + 1: 2^SLOT_W == 1 modulo 2^SLOT_W-1, so sum the digits.
  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [SUM_W-1:0]  s;
    logic [KEY_W-1:0]  tmp;
    logic [FOLD_W-1:0] f;
    s = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      tmp = key >> (i * SLOT_W);
      s   = s + SUM_W'(tmp[SLOT_W-1:0]);
    end
    f = FOLD_W'(s[SLOT_W-1:0]) + FOLD_W'(s[SUM_W-1:SLOT_W]);
    if (f >= HOME_MOD) begin
      f = f - HOME_MOD;
    end
    return f[SLOT_W-1:0] + FIRST_SLOT;
  endfunction

  // Probe step, wrapping from the last slot back to slot 1.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    return (p == LAST_SLOT) ? FIRST_SLOT : p + FIRST_SLOT;
  endfunction

endpackage

### design/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front
// Takes requests, computes the home slot and hands them to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpht_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0]  in_key_id,
  input  logic [lpht_pkg::VAL_W-1:0]  in_entry_value,
  input  logic                        clearing,
  output logic                        q_push,
  output lpht_pkg::req_t              q_req,
  input  logic                        q_ready
);

  logic           s_valid_r, s_valid_nxt;
  lpht_pkg::req_t s_req_r;
  logic           accept;

  assign q_push   = s_valid_r && q_ready;
  assign q_req    = s_req_r;
  assign in_stall = clearing || (s_valid_r && !q_ready);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (accept) begin
      s_valid_nxt = 1'b1;
    end else if (q_push) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_req_r.op    <= in_opcode;
      s_req_r.key   <= in_key_id;
      s_req_r.value <= in_entry_value;
      s_req_r.home  <= lpht_pkg::home_slot(in_key_id);
    end
  end

  // a request blocked by a full queue must sit unchanged
  `ASSERT_PROP(fr_hold, s_valid_r && !q_ready |=> s_valid_r && $stable(s_req_r), "front lost request")

endmodule

### design/lpht_queue.sv
// ----------------------------------------------------------------------------
// lpht_queue
// Short FIFO decoupling the front stage from the probe engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpht_pkg::req_t push_req,
  output logic           ready,
  input  logic           pop,
  output lpht_pkg::req_t head,
  output logic           valid
);

  lpht_pkg::req_t                ent_r [lpht_pkg::QUEUE_DEPTH];
  logic [lpht_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [lpht_pkg::QPTR_W:0]     cnt_r, cnt_nxt;

  assign ready = cnt_r != (lpht_pkg::QPTR_W + 1)'(lpht_pkg::QUEUE_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_req;
    end
  end

  `ASSERT_NEVER(q_overflow, push && !ready, "queue overflow")
  `ASSERT_NEVER(q_underflow, pop && !valid, "queue underflow")

endmodule

### design/lpht_back.sv
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: slot memory, clearing pass, probe walk and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpht_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lpht_pkg::req_t               q_req,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lpht_pkg::SLOT_W-1:0]  out_slot_index,
  output logic                         out_hit,
  output logic                         out_table_full,
  output logic [lpht_pkg::VAL_W-1:0]   out_found_value
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [lpht_pkg::SLOT_W-1:0] clr_r, clr_nxt;
  logic [lpht_pkg::SLOT_W-1:0] p_r, p_nxt;
  lpht_pkg::req_t              req_r, req_nxt;

  lpht_pkg::slot_t             mem [lpht_pkg::TABLE_SIZE];
  lpht_pkg::slot_t             rd_q;
  logic [lpht_pkg::SLOT_W-1:0] rd_addr, waddr;
  lpht_pkg::slot_t             wdata;
  logic                        we;

  logic                        out_valid_r;
  logic [lpht_pkg::SLOT_W-1:0] out_slot_r, ld_slot;
  logic                        out_hit_r, ld_hit;
  logic                        out_full_r, ld_full;
  logic [lpht_pkg::VAL_W-1:0]  out_value_r, ld_value;
  logic                        ld;

  logic [lpht_pkg::SLOT_W-1:0] nxt_p;
  logic                        match, occupied, wrap, out_free;

  assign nxt_p    = lpht_pkg::next_slot(p_r);
  assign match    = rd_q.valid && (rd_q.key == req_r.key);
  assign occupied = rd_q.valid && !match;
  assign wrap     = nxt_p == req_r.home;
  assign out_free = !out_valid_r || !out_stall;
  assign clearing = state_r == ST_CLEAR;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    p_nxt     = p_r;
    req_nxt   = req_r;
    rd_addr   = p_r;
    we        = 1'b0;
    waddr     = p_r;
    wdata     = {1'b1, req_r.key, req_r.value};
    q_pop     = 1'b0;
    ld        = 1'b0;
    ld_slot   = '0;
    ld_hit    = 1'b0;
    ld_full   = 1'b0;
    ld_value  = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + lpht_pkg::FIRST_SLOT;
        if (clr_r == lpht_pkg::LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rd_addr   = q_req.home;
          p_nxt     = q_req.home;
          req_nxt   = q_req;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (occupied && !wrap) begin
          // read ahead so the next slot's data lands next cycle
          p_nxt   = nxt_p;
          rd_addr = nxt_p;
        end else if (out_free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
          if (occupied) begin
            ld_full = 1'b1;
          end else if (req_r.op == lpht_pkg::OP_INSERT) begin
            we       = 1'b1;
            ld_slot  = p_r;
            ld_hit   = 1'b1;
            ld_value = req_r.value;
          end else if (match) begin
            ld_slot  = p_r;
            ld_hit   = 1'b1;
            ld_value = rd_q.value;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    req_r <= req_nxt;
    if (ld) begin
      out_slot_r  <= ld_slot;
      out_hit_r   <= ld_hit;
      out_full_r  <= ld_full;
      out_value_r <= ld_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_index  = out_slot_r;
  assign out_hit         = out_hit_r;
  assign out_table_full  = out_full_r;
  assign out_found_value = out_value_r;

  `ASSERT_NEVER(bk_hit_full, out_valid_r && out_hit_r && out_full_r, "hit and full together")
  `ASSERT_PROP(bk_hit_slot, out_valid_r && out_hit_r |-> out_slot_r != '0, "hit on slot zero")
  `ASSERT_PROP(bk_probe_slot, state_r == ST_PROBE |-> p_r != '0, "probe reached slot zero")

endmodule

### design/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing.
// Requests: the probe engine finishes each request before it takes the next,
//   probing slots in turn through the single-read-port slot memory.
// Path: request register with home slot, queue, probe walk, result register.
// Reset: synchronous; a clearing pass then zeroes all 1024 slots
//   with in_stall high.
// ----------------------------------------------------------------------------

module linear_probe_hash_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0]   in_key_id,
  input  logic [lpht_pkg::VAL_W-1:0]   in_entry_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lpht_pkg::SLOT_W-1:0]  out_slot_index,
  output logic                         out_hit,
  output logic                         out_table_full,
  output logic [lpht_pkg::VAL_W-1:0]   out_found_value
);

  // Front: registers the request with its home slot (key mod 1023 + 1,
  // computed by folding 10-bit digits). Queue: two entries, so the front keeps
  // taking requests while the probe engine walks a chain or a result waits.
  // Back: walks slots one per cycle, reading ahead, and writes on insert.

  logic           clearing;
  logic           q_push, q_ready, q_pop, q_valid;
  lpht_pkg::req_t q_in, q_head;

  lpht_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_key_id      (in_key_id),
    .in_entry_value (in_entry_value),
    .clearing       (clearing),
    .q_push         (q_push),
    .q_req          (q_in),
    .q_ready        (q_ready)
  );

  lpht_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_in),
    .ready    (q_ready),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid)
  );

  // the back end also owns the output register, so a stalled result never
  // blocks the front from filling the queue
  lpht_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_req           (q_head),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_index  (out_slot_index),
    .out_hit         (out_hit),
    .out_table_full  (out_table_full),
    .out_found_value (out_found_value)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: linear probe hash table unit testbench
// Sends lookup and insert requests over the valid/stall request channel. A
// shadow copy of the slot table predicts each result when its request is
// taken, and the results are checked in order. Coverage includes home-slot
// collisions, probes that wrap past the last slot, overwrites, zero values,
// and the full table. Sender and receiver idle at random, phase by phase.
// ----------------------------------------------------------------------------
module tb;
  localparam int   TABLE_SIZE = lpht_pkg::TABLE_SIZE;
  localparam int   SLOT_W     = lpht_pkg::SLOT_W;
  localparam int   KEY_W      = lpht_pkg::KEY_W;
  localparam int   VAL_W      = lpht_pkg::VAL_W;
  localparam logic OP_LOOKUP  = lpht_pkg::OP_LOOKUP;
  localparam logic OP_INSERT  = lpht_pkg::OP_INSERT;

  localparam int KEY_POOL_SIZE    = 320;
  localparam int RANDOM_PER_PHASE = 260;
  localparam int SETTLE_CYCLES    = 64;
  localparam int REPORT_LIMIT     = 10;
  // largest m with (TABLE_SIZE-2) + (TABLE_SIZE-1)*m still inside 32 bits
  localparam longint MAX_MULT = (64'hFFFF_FFFF - (TABLE_SIZE - 2)) / (TABLE_SIZE - 1);

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } table_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              full;
    logic [VAL_W-1:0]  value;
  } probe_result_t;

  // DUT ports. Every input starts at a known value.
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_opcode      = OP_LOOKUP;
  logic [KEY_W-1:0]  in_key_id      = '0;
  logic [VAL_W-1:0]  in_entry_value = '0;
  logic              out_stall      = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [SLOT_W-1:0] out_slot_index;
  logic              out_hit;
  logic              out_table_full;
  logic [VAL_W-1:0]  out_found_value;

  linear_probe_hash_table_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key_id       (in_key_id),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_index  (out_slot_index),
    .out_hit         (out_hit),
    .out_table_full  (out_table_full),
    .out_found_value (out_found_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow slot table. Slot 0 is never used.
  bit               shadow_valid [TABLE_SIZE];
  logic [KEY_W-1:0] shadow_key   [TABLE_SIZE];
  logic [VAL_W-1:0] shadow_value [TABLE_SIZE];

  table_req_t    request_queue[$];     // requests waiting to be driven
  probe_result_t expected_results[$];  // predictions for taken requests, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit req_taken      = 1'b0;  // handshake seen at the last rising edge
  int error_count    = 0;
  int lookup_count   = 0;
  int insert_count   = 0;
  int hit_count      = 0;
  int full_count     = 0;

  // Walk the probe chain for one request and apply it to the shadow table.
  function automatic probe_result_t probe_table(input table_req_t req);
    probe_result_t res;
    int            home;
    int            p;
    bit            full;
    res  = '0;
    home = int'(req.key % KEY_W'(TABLE_SIZE - 1)) + 1;
    p    = home;
    full = 1'b0;
    // stop at the key, an empty slot, or back at home (table full)
    while (!full && shadow_valid[p] && shadow_key[p] != req.key) begin
      p = (p == TABLE_SIZE - 1) ? 1 : p + 1;
      if (p == home) begin
        full = 1'b1;
      end
    end
    if (full) begin
      // full table: nothing found, nothing stored
      res.full = 1'b1;
    end else begin
      if (req.op == OP_INSERT) begin
        shadow_valid[p] = 1'b1;
        shadow_key[p]   = req.key;
        shadow_value[p] = req.value;
      end
      // lookup miss leaves the result all zero
      if (shadow_valid[p]) begin
        res.slot  = SLOT_W'(p);
        res.hit   = 1'b1;
        res.value = shadow_value[p];
      end
    end
    return res;
  endfunction

  // Some key whose home slot is h.
  function automatic logic [KEY_W-1:0] key_homed_at(input int h);
    return KEY_W'(h - 1) + KEY_W'(TABLE_SIZE - 1) * KEY_W'($urandom_range(0, 32'(MAX_MULT)));
  endfunction

  function automatic void push_req(input logic op, input logic [KEY_W-1:0] key,
                                   input logic [VAL_W-1:0] value);
    request_queue.push_back(table_req_t'{op, key, value});
  endfunction

  // Wait until every queued request is taken and every result is back.
  task automatic wait_drained();
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Request capture: predict at the edge where the request is taken. Inputs
  // only move on the falling edge, so the sampled payload is the taken one.
  always @(posedge clk) begin : capture
    table_req_t taken;
    req_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      req_taken = 1'b1;
      taken     = table_req_t'{in_opcode, in_key_id, in_entry_value};
      if (in_opcode == OP_INSERT) begin
        insert_count++;
      end else begin
        lookup_count++;
      end
      expected_results.push_back(probe_table(taken));
    end
  end

  // Request driver: a fresh request or an idle cycle whenever the channel is
  // free; a stalled request holds its payload.
  always @(negedge clk) begin : drive
    table_req_t next_req;
    if (rst_n && (!in_valid || req_taken)) begin
      if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = request_queue.pop_front();
        in_valid       <= 1'b1;
        in_opcode      <= next_req.op;
        in_key_id      <= next_req.key;
        in_entry_value <= next_req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: each taken result against the oldest prediction.
  always @(posedge clk) begin : check
    probe_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (error_count < REPORT_LIMIT) begin
          $display("ERROR: unexpected result slot=%0d hit=%0b full=%0b value=%h",
                   out_slot_index, out_hit, out_table_full, out_found_value);
        end
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_slot_index !== want.slot || out_hit !== want.hit ||
            out_table_full !== want.full || out_found_value !== want.value) begin
          if (error_count < REPORT_LIMIT) begin
            $display("ERROR: slot=%0d hit=%0b full=%0b value=%h, expected %0d %0b %0b %h",
                     out_slot_index, out_hit, out_table_full, out_found_value,
                     want.slot, want.hit, want.full, want.value);
          end
          error_count++;
        end
        hit_count  += want.hit;
        full_count += want.full;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin : backpressure
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Stimulus.
  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    logic [KEY_W-1:0] corner_keys [4];
    int               send_pct [4];
    int               recv_pct [4];
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] fill_key;
    int               pick;
    int               cluster_base;

    corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'(TABLE_SIZE - 2), 32'(TABLE_SIZE - 1)};
    send_pct    = '{0, 48, 0, 9};
    recv_pct    = '{0, 0, 48, 9};
    fill_key    = '0;

    // Key pool: a third random, a third piled on the homes around the wrap
    // point, a third piled on a small cluster somewhere in the middle.
    cluster_base = $urandom_range(100, TABLE_SIZE - 120);
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      unique case (i % 3)
        0: begin
          key_pool[i] = $urandom();
        end
        1: begin
          pick        = $urandom_range(0, 5);
          key_pool[i] = key_homed_at(pick < 4 ? TABLE_SIZE - 4 + pick : pick - 3);
        end
        default: begin
          key_pool[i] = key_homed_at(cluster_base + $urandom_range(0, 7));
        end
      endcase
    end

    // Synchronous reset, released on a falling edge. The DUT
    // then clears its table with in_stall high; the driver just waits.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests on the empty table, no idling.
    push_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // absent key
    push_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);  // key 0 lands in slot 1
    push_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(OP_INSERT, 32'h0000_0000, 32'h0000_0001);  // overwrite
    push_req(OP_LOOKUP, 32'h0000_0000, 32'hDEAD_BEEF);  // value ignored on lookup
    push_req(OP_INSERT, 32'(TABLE_SIZE - 1), 32'h1234_5678);  // collides on slot 1
    push_req(OP_INSERT, 32'hFFFF_FFFF, 32'h8765_4321);
    push_req(OP_INSERT, 32'(TABLE_SIZE - 2), 32'hAAAA_AAAA);  // home is the last slot
    // home on the last slot again: probe wraps to slot 1 and on
    push_req(OP_INSERT, 32'(2 * TABLE_SIZE - 3), 32'h5555_5555);
    push_req(OP_LOOKUP, 32'(2 * TABLE_SIZE - 3), 32'h0000_0000);
    push_req(OP_LOOKUP, 32'(3 * TABLE_SIZE - 4), 32'h0000_0000);  // absent, wrapped chain
    push_req(OP_INSERT, 32'h5555_5555, 32'h0000_0000);  // zero value is still stored
    push_req(OP_LOOKUP, 32'h5555_5555, 32'h0000_0000);
    push_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    push_req(OP_LOOKUP, 32'(TABLE_SIZE - 1), 32'h0000_0000);
    push_req(OP_INSERT, 32'(TABLE_SIZE - 1), 32'h7FFF_FFFF);
    push_req(OP_LOOKUP, 32'(TABLE_SIZE - 1), 32'h0000_0000);
    wait_drained();

    // Random requests, one phase per idling mode. Mostly pool keys, so that
    // inserts and later lookups of the same key pair up.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end else if (pick < 90) begin
          key = $urandom();
        end else begin
          key = corner_keys[$urandom_range(0, 3)];
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          value = '0;
        end else if (pick < 10) begin
          value = '1;
        end else begin
          value = $urandom();
        end
        push_req($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, key, value);
      end
      wait_drained();
    end

    // Fill every empty slot with a key homed there, so each insert stops at
    // its home. Slots are never freed, so no key homed on an empty slot can
    // already be in the table.
    for (int s = 1; s < TABLE_SIZE; s++) begin
      if (!shadow_valid[s]) begin
        fill_key = key_homed_at(s);
        push_req(OP_INSERT, fill_key, $urandom());
      end
    end
    wait_drained();

    // Full table: absent keys scan the whole table, present keys still hit.
    push_req(OP_LOOKUP, $urandom(), 32'h0000_0000);
    push_req(OP_INSERT, $urandom(), $urandom());  // must change nothing
    push_req(OP_LOOKUP, fill_key, 32'h0000_0000);
    push_req(OP_INSERT, fill_key, 32'h0000_0000);
    push_req(OP_LOOKUP, fill_key, 32'h0000_0000);
    push_req(OP_INSERT, 32'h0000_0000, $urandom());
    push_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(OP_INSERT, 32'(3 * TABLE_SIZE - 4), 32'hFFFF_FFFF);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d lookups and %0d inserts: %0d hits, %0d full-table results.",
             lookup_count, insert_count, hit_count, full_count);
    $display("Idling modes: none, sender, receiver, both; then a fill to full. Errors: %0d.",
             error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog. The slowest correct run covers the clearing pass, ~1750 requests
  // with probe chains of at most a few hundred slots, each result waiting out
  // stalls, plus a handful of full-table scans; the limit is set well above
  // that.
  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
